FILE: src/bmd_pkg.sv
// Package with shared constants, types and functions of the majority-vote button debouncer.
`timescale 1ns / 1ps

package bmd_pkg;

    localparam int NUM_BUTTONS  = 8;
    localparam int HISTORY_LEN  = 16;
    localparam int IN_W         = 8;
    localparam int PTR_W        = $clog2(HISTORY_LEN);
    localparam int THR_W        = 5;
    localparam int CNT_W        = $clog2(HISTORY_LEN + 1);
    localparam int IDX_W        = 3;
    localparam int OUT_DATA_W   = 8;
    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam logic [THR_W-1:0] THR_RESET = THR_W'((HISTORY_LEN * 5) / 6);
    localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(HISTORY_LEN - 1);

    typedef logic [NUM_BUTTONS-1:0] press_mask_t;

    typedef struct packed {
        logic not_full;
        logic not_empty;
    } q_status_t;

    function automatic logic [IDX_W-1:0] lowest_index(input press_mask_t mask);
        logic [IDX_W-1:0] idx;
        idx = '0;
        for (int i = NUM_BUTTONS - 1; i >= 0; i--) begin
            if (mask[i]) begin
                idx = IDX_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

FILE: src/multi_button_majority_debouncer.sv
// Top level of the majority-vote debouncer for eight pulled-up buttons.
// Usage:
//   s_ channel: one word per polling tick, s_tdata[7:0] = pin levels (1 = released).
//   m_ channel: one word per press event, m_tdata[2:0] = button index, m_tlast
//     marks the final press of a tick; ticks without a press produce no word.
//   cfg_wr_en / cfg_wr_data: write the up threshold (count of high samples that
//     must be exceeded to read as released); write only while the block is idle.
// Event path: accepting a tick updates the state and queues its press mask;
//   the output register then loads the first event of the tick from the queue
//   and raises m_tvalid when the output side is free.
// Throughput: one tick per cycle at the input while the two-entry press queue
//   has room; one event per cycle at the output while m_tready is high, set by
//   the single-event output register; a tick yields up to eight events.
// Reset: sample rings, counts, ring pointer and debounced states clear to zero,
//   the threshold returns to 13, queue and output empty; no clearing pass.
// Stall: when m_tready is low the event holds; pending masks fill the queue and
//   s_tready drops once it is full.
`timescale 1ns / 1ps

module multi_button_majority_debouncer import bmd_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [THR_W-1:0]      cfg_wr_data,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_W-1:0]       s_tdata,   // [7:0] pin_levels
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // [2:0] button_index, [7:3] zero
    output logic                  m_tlast    // last_event
);

    q_status_t   q_status;
    logic        push;
    press_mask_t push_mask;
    logic        pop;
    press_mask_t pop_mask;

    bmd_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .q_status    (q_status),
        .push        (push),
        .push_mask   (push_mask)
    );

    bmd_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_mask (push_mask),
        .pop       (pop),
        .pop_mask  (pop_mask),
        .q_status  (q_status)
    );

    bmd_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_status (q_status),
        .pop_mask (pop_mask),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

`ifndef SYNTHESIS
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    a_push_room: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> q_status.not_full)
        else $error("press queue overflow");

    a_pop_data: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> q_status.not_empty)
        else $error("press queue underflow");

    a_pop_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> (pop_mask != '0))
        else $error("empty press mask queued");
`endif

endmodule

FILE: src/bmd_front.sv
// Front end: sample rings, running counts, debounced state and press detection per tick.
`timescale 1ns / 1ps

module bmd_front import bmd_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [THR_W-1:0]  cfg_wr_data,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [IN_W-1:0]   s_tdata,   // [7:0] pin_levels
    input  q_status_t         q_status,
    output logic              push,
    output press_mask_t       push_mask
);

    logic [HISTORY_LEN-1:0] hist_reg  [NUM_BUTTONS];
    logic [HISTORY_LEN-1:0] hist_next [NUM_BUTTONS];
    logic [CNT_W-1:0]       cnt_reg   [NUM_BUTTONS];
    logic [CNT_W-1:0]       cnt_next  [NUM_BUTTONS];
    logic [NUM_BUTTONS-1:0] up_reg;
    logic [NUM_BUTTONS-1:0] up_next;
    logic [PTR_W-1:0]       ptr_reg;
    logic [PTR_W-1:0]       ptr_next;
    logic [THR_W-1:0]       thr_reg;
    logic                   accept;
    press_mask_t            press;

    assign s_tready = q_status.not_full;
    assign accept   = s_tvalid && s_tready;
    assign ptr_next = (ptr_reg == PTR_LAST) ? '0 : ptr_reg + 1'b1;

    always_comb begin
        for (int i = 0; i < NUM_BUTTONS; i++) begin
            logic level;
            logic old_bit;
            level   = (i < IN_W) ? s_tdata[i] : 1'b0;
            old_bit = hist_reg[i][ptr_next];
            hist_next[i] = hist_reg[i];
            hist_next[i][ptr_next] = level;
            cnt_next[i] = cnt_reg[i] + CNT_W'(level) - CNT_W'(old_bit);
            up_next[i]  = (THR_W'(cnt_next[i]) > thr_reg);
            press[i]    = up_reg[i] && !up_next[i];
        end
    end

    assign push      = accept && (press != '0);
    assign push_mask = press;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_BUTTONS; i++) begin
                hist_reg[i] <= '0;
                cnt_reg[i]  <= '0;
            end
            up_reg  <= '0;
            ptr_reg <= '0;
            thr_reg <= THR_RESET;
        end else begin
            if (cfg_wr_en) begin
                thr_reg <= cfg_wr_data;
            end
            if (accept) begin
                for (int i = 0; i < NUM_BUTTONS; i++) begin
                    hist_reg[i] <= hist_next[i];
                    cnt_reg[i]  <= cnt_next[i];
                end
                up_reg  <= up_next;
                ptr_reg <= ptr_next;
            end
        end
    end

endmodule

FILE: src/bmd_queue.sv
// Short queue of press masks between the front end and the event emitter.
`timescale 1ns / 1ps

module bmd_queue import bmd_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        push,
    input  press_mask_t push_mask,
    input  logic        pop,
    output press_mask_t pop_mask,
    output q_status_t   q_status
);

    press_mask_t       mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] cnt_reg;
    logic [QCNT_W-1:0] cnt_next;

    assign pop_mask           = mem_reg[rd_ptr_reg];
    assign q_status.not_full  = (cnt_reg != QCNT_W'(QUEUE_DEPTH));
    assign q_status.not_empty = (cnt_reg != '0);
    assign cnt_next           = cnt_reg + QCNT_W'(push) - QCNT_W'(pop);

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_mask;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                       : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                       : rd_ptr_reg + 1'b1;
            end
            cnt_reg <= cnt_next;
        end
    end

endmodule

FILE: src/bmd_back.sv
// Back end: split each press mask into index-ordered event words with a last marker.
`timescale 1ns / 1ps

module bmd_back import bmd_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  q_status_t             q_status,
    input  press_mask_t           pop_mask,
    output logic                  pop,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // [2:0] button_index, [7:3] zero
    output logic                  m_tlast    // last_event
);

    press_mask_t      mask_reg;
    press_mask_t      src;
    press_mask_t      rest;
    logic             out_valid_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx;
    logic             last_reg;
    logic             advance;
    logic             have;

    assign advance = !out_valid_reg || m_tready;
    assign have    = (mask_reg != '0) || q_status.not_empty;
    assign src     = (mask_reg != '0) ? mask_reg : pop_mask;
    assign idx     = lowest_index(src);
    assign rest    = src & (src - 1'b1);
    assign pop     = advance && (mask_reg == '0) && q_status.not_empty;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_DATA_W'(idx_reg);
    assign m_tlast  = last_reg;

    always_ff @(posedge aclk) begin
        if (advance && have) begin
            idx_reg  <= idx;
            last_reg <= (rest == '0);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            mask_reg      <= '0;
        end else if (advance) begin
            out_valid_reg <= have;
            if (have) begin
                mask_reg <= rest;
            end
        end
    end

endmodule
